>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the quaternion unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/qau_pkg.sv
// Shared types, constants and the sigmoid table of the quaternion unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

  localparam int COMP_W      = 16;
  localparam int FRAC_W      = 12;
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
  localparam int SIG_VAL_W   = FRAC_W + 1;
  localparam int LANES       = 4;
  localparam int LANE_IDX_W  = $clog2(LANES);

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef comp_t [LANES-1:0]        quat_t;
  typedef logic [LANE_IDX_W-1:0]    lane_idx_t;
  typedef logic [SIG_VAL_W-1:0]     sig_val_t;
  typedef sig_val_t                 sig_tab_t [SIG_ENTRIES];

  localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_CONJ         = 3'd0,
    KIND_SUM          = 3'd1,
    KIND_DIFF         = 3'd2,
    KIND_HAMILTON     = 3'd3,
    KIND_SCALE        = 3'd4,
    KIND_SIGMOID      = 3'd5,
    KIND_SIGMOID_DERIV = 3'd6
  } kind_e;

  typedef struct packed {
    logic [2:0] kind;
    comp_t      a_real;
    comp_t      a_i;
    comp_t      a_j;
    comp_t      a_k;
    comp_t      b_real;
    comp_t      b_i;
    comp_t      b_j;
    comp_t      b_k;
    comp_t      scale_factor;
  } req_t;

  typedef struct packed {
    comp_t res_real;
    comp_t res_i;
    comp_t res_j;
    comp_t res_k;
    logic  overflow;
  } rsp_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctrl_t;

  // Hamilton product terms per result component: a index, b index, negate.
  localparam lane_idx_t HAM_A_SEL [LANES][LANES] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd3, 2'd1, 2'd2, 2'd0},
    '{2'd1, 2'd2, 2'd3, 2'd0}
  };
  localparam lane_idx_t HAM_B_SEL [LANES][LANES] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd3, 2'd2, 2'd0, 2'd1},
    '{2'd1, 2'd3, 2'd0, 2'd2},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };
  localparam logic HAM_NEG [LANES][LANES] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0}
  };

  // Divide by shift and subtract; runs only while the table is built.
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-|x|) by Taylor series on |x|/16, squared four times, then 1/(1+e) for x >= 0 and e/(1+e) below.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t          tab;
    longint unsigned   m;
    longint unsigned   u;
    longint unsigned   r;
    longint unsigned   den;
    longint unsigned   num;
    logic              pos;
    for (int n = 0; n < SIG_ENTRIES; n++) begin
      pos = (2 * n >= SIG_ENTRIES);
      if (pos) begin
        m = longint'(2 * n - SIG_ENTRIES);
      end else begin
        m = longint'(SIG_ENTRIES - 2 * n);
      end
      u = udiv(m << 30, 64'(2 * SIG_ENTRIES));
      r = Q30_ONE;
      for (int k = 10; k >= 1; k--) begin
        r = Q30_ONE - udiv((u * r) >> 30, 64'(k));
      end
      for (int s = 0; s < 4; s++) begin
        r = (r * r) >> 30;
      end
      den = Q30_ONE + r;
      num = pos ? Q30_ONE : r;
      tab[n] = sig_val_t'(udiv((num << FRAC_W) + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

>>> hw/rtl/quaternion_arithmetic_unit_top.sv
// Quaternion arithmetic unit: conjugate, sum, difference, Hamilton product,
// scaling, sigmoid and sigmoid derivative on Q3.12 components, saturating with
// an overflow flag. Takes one request per cycle while req_stall is low. Four
// lanes, one per component, each with four multipliers, a registered product
// stage and a registered sum-round-saturate stage, feed an output register.
// A stalled output holds its response while empty pipeline stages keep taking
// requests. Depends on qau_pkg, qau_lane, qau_merge.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  qau_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output qau_pkg::rsp_t rsp_data
);

  qau_pkg::quat_t              a;
  qau_pkg::quat_t              b;
  qau_pkg::quat_t              lane_res;
  logic [qau_pkg::LANES-1:0]   lane_ov;
  qau_pkg::lane_ctrl_t         ctrl;

  logic s1_valid;
  logic s2_valid;
  logic s1_ready;
  logic s2_ready;
  logic take;

  assign a = {req_data.a_k, req_data.a_j, req_data.a_i, req_data.a_real};
  assign b = {req_data.b_k, req_data.b_j, req_data.b_i, req_data.b_real};

  assign s2_ready   = !s2_valid || take;
  assign s1_ready   = !s1_valid || s2_ready;
  assign req_stall  = !s1_ready;
  assign ctrl.s1_en = s1_ready && req_valid;
  assign ctrl.s2_en = s2_ready && s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= req_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  for (genvar g = 0; g < qau_pkg::LANES; g++) begin : g_lane
    qau_lane #(
      .LANE (g)
    ) u_lane (
      .clk   (clk),
      .kind  (req_data.kind),
      .a     (a),
      .b     (b),
      .scale (req_data.scale_factor),
      .ctrl  (ctrl),
      .res   (lane_res[g]),
      .ov    (lane_ov[g])
    );
  end

  qau_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (s2_valid),
    .lane_res   (lane_res),
    .lane_ov    (lane_ov),
    .stall      (rsp_stall),
    .take       (take),
    .valid      (rsp_valid),
    .data       (rsp_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/qau_lane.sv
// One result component: operand select and products (or a direct value), then sum, round, saturate.
// Depends on qau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qau_lane #(
  parameter int LANE = 0
) (
  input  logic               clk,
  input  logic [2:0]         kind,
  input  qau_pkg::quat_t     a,
  input  qau_pkg::quat_t     b,
  input  qau_pkg::comp_t     scale,
  input  qau_pkg::lane_ctrl_t ctrl,
  output qau_pkg::comp_t     res,
  output logic               ov
);

  localparam int CW      = qau_pkg::COMP_W;
  localparam int FW      = qau_pkg::FRAC_W;
  localparam int MUL_W   = 2 * CW + 1;
  localparam int PROD_W  = 2 * CW + 2;
  localparam int SUM_W   = PROD_W + 2;
  localparam int DIR_W   = CW + 2;
  localparam int V_W     = CW + 2;
  localparam int IDXF_W  = V_W + $clog2(qau_pkg::SIG_ENTRIES + 1);
  localparam int LN      = qau_pkg::LANES;

  typedef logic signed [CW:0]       opy_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic signed [V_W-1:0]    v_t;
  typedef logic [IDXF_W-1:0]        idxf_t;

  localparam opy_t ONE        = opy_t'(1 << FW);
  localparam v_t   SIG_OFFSET = v_t'(8 << FW);
  localparam sum_t HALF       = sum_t'(1 << (FW - 1));

  qau_pkg::comp_t a_own;
  qau_pkg::comp_t b_own;
  opy_t           one_minus;
  v_t             sig_v;
  idxf_t          idx_full;
  logic [qau_pkg::SIG_IDX_W-1:0] sig_idx;
  qau_pkg::sig_val_t sig_val;

  qau_pkg::comp_t mx [LN];
  opy_t           my [LN];
  logic           neg [LN];
  mul_t           raw [LN];

  prod_t term_next [LN];
  logic  prod_sel_next;
  dir_t  direct_next;

  prod_t term [LN];
  logic  prod_sel;
  dir_t  direct;

  sum_t           acc;
  sum_t           value;
  qau_pkg::comp_t res_next;
  logic           ov_next;

  assign a_own     = a[LANE];
  assign b_own     = b[LANE];
  assign one_minus = ONE - opy_t'(a_own);

  always_comb begin
    sig_v    = v_t'(a_own) + SIG_OFFSET;
    idx_full = '0;
    if (sig_v > v_t'(0)) begin
      idx_full = (idxf_t'(sig_v) * idxf_t'(qau_pkg::SIG_ENTRIES)) >> (FW + 4);
    end
    if (idx_full > idxf_t'(qau_pkg::SIG_ENTRIES - 1)) begin
      sig_idx = qau_pkg::SIG_IDX_W'(qau_pkg::SIG_ENTRIES - 1);
    end else begin
      sig_idx = idx_full[qau_pkg::SIG_IDX_W-1:0];
    end
    sig_val = qau_pkg::SIG_TABLE[sig_idx];
  end

  always_comb begin
    for (int t = 0; t < LN; t++) begin
      mx[t]  = '0;
      my[t]  = '0;
      neg[t] = 1'b0;
    end
    prod_sel_next = 1'b0;
    direct_next   = '0;
    unique case (kind)
      qau_pkg::KIND_CONJ: begin
        direct_next = (LANE == 0) ? dir_t'(a_own) : -dir_t'(a_own);
      end
      qau_pkg::KIND_SUM: begin
        direct_next = dir_t'(a_own) + dir_t'(b_own);
      end
      qau_pkg::KIND_DIFF: begin
        direct_next = dir_t'(a_own) - dir_t'(b_own);
      end
      qau_pkg::KIND_HAMILTON: begin
        prod_sel_next = 1'b1;
        for (int t = 0; t < LN; t++) begin
          mx[t]  = a[qau_pkg::HAM_A_SEL[LANE][t]];
          my[t]  = opy_t'(b[qau_pkg::HAM_B_SEL[LANE][t]]);
          neg[t] = qau_pkg::HAM_NEG[LANE][t];
        end
      end
      qau_pkg::KIND_SCALE: begin
        prod_sel_next = 1'b1;
        mx[0] = scale;
        my[0] = opy_t'(a_own);
      end
      qau_pkg::KIND_SIGMOID: begin
        direct_next = dir_t'(sig_val);
      end
      qau_pkg::KIND_SIGMOID_DERIV: begin
        prod_sel_next = 1'b1;
        mx[0] = a_own;
        my[0] = one_minus;
      end
      default: begin
        direct_next = '0;
      end
    endcase
    for (int t = 0; t < LN; t++) begin
      raw[t]       = mx[t] * my[t];
      term_next[t] = neg[t] ? -prod_t'(raw[t]) : prod_t'(raw[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      term     <= term_next;
      prod_sel <= prod_sel_next;
      direct   <= direct_next;
    end
  end

  always_comb begin
    acc = sum_t'(term[0]) + sum_t'(term[1]) + sum_t'(term[2]) + sum_t'(term[3]) + HALF;
    if (prod_sel) begin
      value = acc >>> FW;
    end else begin
      value = sum_t'(direct);
    end
    ov_next = 1'b0;
    if (value > sum_t'(qau_pkg::COMP_MAX)) begin
      res_next = qau_pkg::COMP_MAX;
      ov_next  = 1'b1;
    end else if (value < sum_t'(qau_pkg::COMP_MIN)) begin
      res_next = qau_pkg::COMP_MIN;
      ov_next  = 1'b1;
    end else begin
      res_next = value[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      res <= res_next;
      ov  <= ov_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qau_merge.sv
// Output stage: joins the four lane results and overflow flags into one response.
// Depends on qau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qau_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       lane_valid,
  input  qau_pkg::quat_t             lane_res,
  input  logic [qau_pkg::LANES-1:0]  lane_ov,
  input  logic                       stall,
  output logic                       take,
  output logic                       valid,
  output qau_pkg::rsp_t              data
);

  assign take = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && lane_valid) begin
      data.res_real <= lane_res[0];
      data.res_i    <= lane_res[1];
      data.res_j    <= lane_res[2];
      data.res_k    <= lane_res[3];
      data.overflow <= |lane_ov;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qau_checker.sv
// Port-level checks of the quaternion unit, bound to the top level.
// Depends on qau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qau_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input qau_pkg::rsp_t rsp_data
);

  logic any_sat;
  logic out_free;

  assign any_sat =
    rsp_data.res_real == qau_pkg::COMP_MAX || rsp_data.res_real == qau_pkg::COMP_MIN ||
    rsp_data.res_i == qau_pkg::COMP_MAX || rsp_data.res_i == qau_pkg::COMP_MIN ||
    rsp_data.res_j == qau_pkg::COMP_MAX || rsp_data.res_j == qau_pkg::COMP_MIN ||
    rsp_data.res_k == qau_pkg::COMP_MAX || rsp_data.res_k == qau_pkg::COMP_MIN;

  assign out_free = !rsp_valid || !rsp_stall;

  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response changed")
  `ASSERT_CLK(a_no_backpressure, clk, rst, out_free |-> !req_stall, "request stalled while output is free")
  `ASSERT_NEVER(a_ovf_sat, clk, rst, rsp_valid && rsp_data.overflow && !any_sat, "overflow without a saturated component")

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (.*);

`default_nettype wire
